/* hdl/qslerp_pkg.sv */
// qslerp_pkg: constants, angle tables and carry types for the quaternion slerp pipeline
// used by quaternion_slerp; no dependencies
`default_nettype none

package qslerp_pkg;

  localparam int FRAC_BITS    = 15;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;
  localparam int DIV_STEPS    = 17;
  localparam int LATENCY      = 123;

  localparam logic [14:0] THRESHOLD_RESET = 15'd32735;
  localparam logic [16:0] ONE             = 17'd1 << FRAC_BITS;

  // angles and sines in q30
  localparam logic signed [35:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q  = 36'sd6746518852;
  localparam logic signed [33:0] GAIN_Q    = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;

  localparam logic signed [15:0] OUT_MAX = 16'sd32767;
  localparam logic signed [15:0] OUT_MIN = -16'sd32768;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    logic [15:0]      t;
    logic             lin;
    logic [3:0][18:0] lf;
  } carry_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] w;
    logic        lin;
    logic        sat;
  } res_t;

  function automatic logic signed [35:0] atan_step(input int i);
    case (i)
      0:       atan_step = 36'sd843314857;
      1:       atan_step = 36'sd497837829;
      2:       atan_step = 36'sd263043837;
      3:       atan_step = 36'sd133525159;
      4:       atan_step = 36'sd67021687;
      5:       atan_step = 36'sd33543516;
      6:       atan_step = 36'sd16775851;
      7:       atan_step = 36'sd8388437;
      8:       atan_step = 36'sd4194283;
      9:       atan_step = 36'sd2097149;
      10:      atan_step = 36'sd1048576;
      default: atan_step = 36'(64'sd1 << (30 - i));
    endcase
  endfunction

endpackage

`default_nettype wire

/* hdl/quaternion_slerp.sv */
// quaternion_slerp: pipelined slerp / normalized lerp of two q1.15 quaternions
// depends on qslerp_pkg (constants, atan table, carry and result types)
// throughput: one beat per cycle; the whole pipeline advances together and
// stalls only when the two-entry output stage is full
// reset: rst (synchronous) clears all valid bits and loads lerp_threshold 32735
`default_nettype none

module quaternion_slerp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] first_z,
  input  logic signed [15:0] first_w,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic signed [15:0] second_z,
  input  logic signed [15:0] second_w,
  input  logic [15:0]        blend,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic               used_linear,
  output logic               saturated
);

  localparam int NC = qslerp_pkg::CORDIC_STEPS;
  localparam int NS = qslerp_pkg::SQRT_STEPS;
  localparam int ND = qslerp_pkg::DIV_STEPS;

  logic [14:0] lerp_threshold;
  logic        en;
  logic        skid_v;
  qslerp_pkg::res_t skid;
  qslerp_pkg::res_t out_r;

  assign cfg_ready  = 1'b1;
  assign en         = !skid_v;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lerp_threshold <= qslerp_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lerp_threshold <= cfg_data;
    end
  end

  // stage 1: products
  logic signed [15:0] in_a [4];
  logic signed [15:0] in_b [4];
  logic signed [16:0] omt_in;
  logic               v1;
  qslerp_pkg::carry_t c1;
  logic signed [31:0] p1 [4];
  logic signed [32:0] la1 [4];
  logic signed [32:0] lb1 [4];

  assign in_a[0] = first_x;
  assign in_a[1] = first_y;
  assign in_a[2] = first_z;
  assign in_a[3] = first_w;
  assign in_b[0] = second_x;
  assign in_b[1] = second_y;
  assign in_b[2] = second_z;
  assign in_b[3] = second_w;
  assign omt_in  = $signed(qslerp_pkg::ONE) - $signed({1'b0, blend});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        c1.a[i] <= in_a[i];
        c1.b[i] <= in_b[i];
        c1.lf[i] <= '0;
        p1[i]   <= in_a[i] * in_b[i];
        la1[i]  <= in_a[i] * omt_in;
        lb1[i]  <= in_b[i] * $signed({1'b0, blend});
      end
      c1.t   <= blend;
      c1.lin <= 1'b0;
    end
  end

  // stage 2: dot product and linear blend sums
  logic               v2;
  qslerp_pkg::carry_t c2;
  logic signed [33:0] dot2;
  logic signed [33:0] l2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2   <= c1;
      dot2 <= 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]) + 34'(p1[3]);
      for (int i = 0; i < 4; i++) begin
        l2[i] <= 34'(la1[i]) + 34'(lb1[i]);
      end
    end
  end

  // stage 3: path choice, rounded blend, clamped dot in q30
  logic               v3;
  qslerp_pkg::carry_t c3;
  qslerp_pkg::carry_t c3_next;
  logic signed [31:0] d3;
  logic signed [33:0] lr2 [4];
  logic signed [18:0] dq2;

  assign dq2 = dot2[33:15];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lr2[i] = l2[i] + 34'sd16384;
    end
  end

  always_comb begin
    c3_next     = c2;
    c3_next.lin = dq2 > $signed({4'b0, lerp_threshold});
    for (int i = 0; i < 4; i++) begin
      c3_next.lf[i] = lr2[i][33:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c3_next;
      // with 15 fraction bits the dot already has 30
      if (dot2 > 34'(qslerp_pkg::ONE_Q30)) begin
        d3 <= qslerp_pkg::ONE_Q30;
      end else if (dot2 < -34'(qslerp_pkg::ONE_Q30)) begin
        d3 <= -qslerp_pkg::ONE_Q30;
      end else begin
        d3 <= dot2[31:0];
      end
    end
  end

  // stage 4: squares
  logic               v4;
  qslerp_pkg::carry_t c4;
  logic signed [31:0] d4;
  logic [37:0]        lsq4 [4];
  logic [61:0]        dd4;
  logic signed [37:0] lsq3 [4];
  logic signed [63:0] dd3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lsq3[i] = $signed(c3.lf[i]) * $signed(c3.lf[i]);
    end
  end
  assign dd3 = d3 * d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4  <= c3;
      d4  <= d3;
      dd4 <= dd3[61:0];
      for (int i = 0; i < 4; i++) begin
        lsq4[i] <= lsq3[i][37:0];
      end
    end
  end

  // square root: one result bit per stage; index 0 holds the radicand
  logic               sq_vld [0:NS];
  qslerp_pkg::carry_t sq_c   [0:NS];
  logic signed [31:0] sq_d   [0:NS];
  logic [61:0]        sq_v   [0:NS];
  logic [61:0]        sq_r   [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c[0] <= c4;
      sq_d[0] <= d4;
      sq_r[0] <= '0;
      if (c4.lin) begin
        sq_v[0] <= 62'(lsq4[0]) + 62'(lsq4[1]) + 62'(lsq4[2]) + 62'(lsq4[3]);
      end else begin
        sq_v[0] <= (62'd1 << 60) - dd4;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] trial;
    assign trial = sq_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[k+1] <= sq_c[k];
        sq_d[k+1] <= sq_d[k];
        if (sq_v[k] >= trial) begin
          sq_v[k+1] <= sq_v[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
        end else begin
          sq_v[k+1] <= sq_v[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
      end
    end
  end

  // arc cosine by cordic vectoring on (d, sin)
  logic               ac_vld [0:NC];
  qslerp_pkg::carry_t ac_c   [0:NC];
  logic [30:0]        ac_s   [0:NC];
  logic signed [33:0] ac_x   [0:NC];
  logic signed [33:0] ac_y   [0:NC];
  logic signed [35:0] ac_z   [0:NC];
  logic [30:0]        root;

  assign root = sq_r[NS][30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ac_vld[0] <= 1'b0;
    end else if (en) begin
      ac_vld[0] <= sq_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac_c[0] <= sq_c[NS];
      ac_s[0] <= root;
      if (sq_d[NS] < 0) begin
        ac_x[0] <= $signed({3'b0, root});
        ac_y[0] <= -34'(sq_d[NS]);
        ac_z[0] <= qslerp_pkg::HALF_PI_Q;
      end else begin
        ac_x[0] <= 34'(sq_d[NS]);
        ac_y[0] <= $signed({3'b0, root});
        ac_z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_acos
    localparam logic signed [35:0] ATN = qslerp_pkg::atan_step(i);
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    assign xs = ac_x[i] >>> i;
    assign ys = ac_y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        ac_vld[i+1] <= 1'b0;
      end else if (en) begin
        ac_vld[i+1] <= ac_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ac_c[i+1] <= ac_c[i];
        ac_s[i+1] <= ac_s[i];
        if (ac_y[i] > 34'sd0) begin
          ac_x[i+1] <= ac_x[i] + ys;
          ac_y[i+1] <= ac_y[i] - xs;
          ac_z[i+1] <= ac_z[i] + ATN;
        end else begin
          ac_x[i+1] <= ac_x[i] - ys;
          ac_y[i+1] <= ac_y[i] + xs;
          ac_z[i+1] <= ac_z[i] - ATN;
        end
      end
    end
  end

  // angles: scale by (1-t) and t, round, then reduce into [-pi, pi]
  logic               g_vld [1:4];
  qslerp_pkg::carry_t g_c   [1:4];
  logic [30:0]        g_s   [1:4];
  logic signed [52:0] g_p   [2];
  logic signed [35:0] g_a2  [2];
  logic signed [35:0] g_a3  [2];
  logic signed [35:0] g_a4  [2];
  logic signed [16:0] omt_g;
  logic signed [52:0] pr1   [2];

  assign omt_g = $signed(qslerp_pkg::ONE) - $signed({1'b0, ac_c[NC].t});
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      pr1[j] = g_p[j] + 53'sd16384;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 4; k++) begin
        g_vld[k] <= 1'b0;
      end
    end else if (en) begin
      g_vld[1] <= ac_vld[NC];
      for (int k = 2; k <= 4; k++) begin
        g_vld[k] <= g_vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_c[1] <= ac_c[NC];
      g_s[1] <= ac_s[NC];
      for (int k = 2; k <= 4; k++) begin
        g_c[k] <= g_c[k-1];
        g_s[k] <= g_s[k-1];
      end
      g_p[0] <= ac_z[NC] * omt_g;
      g_p[1] <= ac_z[NC] * $signed({1'b0, ac_c[NC].t});
      for (int j = 0; j < 2; j++) begin
        g_a2[j] <= pr1[j][50:15];
        // truncating remainder by 2*pi; magnitude stays under 4*pi
        if (g_a2[j] >= qslerp_pkg::TWO_PI_Q) begin
          g_a3[j] <= g_a2[j] - qslerp_pkg::TWO_PI_Q;
        end else if (g_a2[j] <= -qslerp_pkg::TWO_PI_Q) begin
          g_a3[j] <= g_a2[j] + qslerp_pkg::TWO_PI_Q;
        end else begin
          g_a3[j] <= g_a2[j];
        end
        if (g_a3[j] > qslerp_pkg::PI_Q) begin
          g_a4[j] <= g_a3[j] - qslerp_pkg::TWO_PI_Q;
        end else if (g_a3[j] < -qslerp_pkg::PI_Q) begin
          g_a4[j] <= g_a3[j] + qslerp_pkg::TWO_PI_Q;
        end else begin
          g_a4[j] <= g_a3[j];
        end
      end
    end
  end

  // two sine cordics in rotation mode, lane 0 for (1-t), lane 1 for t
  logic               sn_vld [0:NC];
  qslerp_pkg::carry_t sn_c   [0:NC];
  logic [30:0]        sn_s   [0:NC];
  logic signed [33:0] sn_x   [0:NC][2];
  logic signed [33:0] sn_y   [0:NC][2];
  logic signed [35:0] sn_z   [0:NC][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sn_vld[0] <= 1'b0;
    end else if (en) begin
      sn_vld[0] <= g_vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_c[0] <= g_c[4];
      sn_s[0] <= g_s[4];
      for (int j = 0; j < 2; j++) begin
        sn_x[0][j] <= qslerp_pkg::GAIN_Q;
        sn_y[0][j] <= '0;
        if (g_a4[j] > qslerp_pkg::HALF_PI_Q) begin
          sn_z[0][j] <= qslerp_pkg::PI_Q - g_a4[j];
        end else if (g_a4[j] < -qslerp_pkg::HALF_PI_Q) begin
          sn_z[0][j] <= -qslerp_pkg::PI_Q - g_a4[j];
        end else begin
          sn_z[0][j] <= g_a4[j];
        end
      end
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_sine
    localparam logic signed [35:0] ATN = qslerp_pkg::atan_step(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        sn_vld[i+1] <= 1'b0;
      end else if (en) begin
        sn_vld[i+1] <= sn_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sn_c[i+1] <= sn_c[i];
        sn_s[i+1] <= sn_s[i];
        for (int j = 0; j < 2; j++) begin
          if (sn_z[i][j] >= 36'sd0) begin
            sn_x[i+1][j] <= sn_x[i][j] - (sn_y[i][j] >>> i);
            sn_y[i+1][j] <= sn_y[i][j] + (sn_x[i][j] >>> i);
            sn_z[i+1][j] <= sn_z[i][j] - ATN;
          end else begin
            sn_x[i+1][j] <= sn_x[i][j] + (sn_y[i][j] >>> i);
            sn_y[i+1][j] <= sn_y[i][j] - (sn_x[i][j] >>> i);
            sn_z[i+1][j] <= sn_z[i][j] + ATN;
          end
        end
      end
    end
  end

  // numerators: weighted products, then sum or scaled blend, then divider operands
  logic               n1_vld;
  qslerp_pkg::carry_t n1_c;
  logic [30:0]        n1_s;
  logic signed [49:0] n1_pa [4];
  logic signed [49:0] n1_pb [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_vld <= 1'b0;
    end else if (en) begin
      n1_vld <= sn_vld[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_c <= sn_c[NC];
      n1_s <= sn_s[NC];
      for (int i = 0; i < 4; i++) begin
        n1_pa[i] <= $signed(sn_c[NC].a[i]) * sn_y[NC][0];
        n1_pb[i] <= $signed(sn_c[NC].b[i]) * sn_y[NC][1];
      end
    end
  end

  logic signed [50:0] num1 [4];
  logic [50:0]        mag1 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (n1_c.lin) begin
        num1[i] = 51'($signed(n1_c.lf[i])) <<< qslerp_pkg::FRAC_BITS;
      end else begin
        num1[i] = 51'(n1_pa[i]) + 51'(n1_pb[i]);
      end
      mag1[i] = num1[i][50] ? 51'(-num1[i]) : 51'(num1[i]);
    end
  end

  logic        n2_vld;
  logic        n2_lin;
  logic [30:0] n2_den;
  logic [51:0] n2_n   [4];
  logic [3:0]  n2_neg;
  logic [3:0]  n2_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_vld <= 1'b0;
    end else if (en) begin
      n2_vld <= n1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_lin <= n1_c.lin;
      n2_den <= n1_s;
      for (int i = 0; i < 4; i++) begin
        n2_n[i]   <= {mag1[i], 1'b0} + 52'(n1_s);
        n2_neg[i] <= num1[i][50];
        n2_nz[i]  <= num1[i] != 51'sd0;
      end
    end
  end

  // restoring division of (2|n| + den) by 2*den, quotient bits 16 down to 0
  logic        dv_vld  [0:ND];
  logic        dv_lin  [0:ND];
  logic [30:0] dv_den  [0:ND];
  logic        dv_zero [0:ND];
  logic [3:0]  dv_neg  [0:ND];
  logic [3:0]  dv_nz   [0:ND];
  logic [3:0]  dv_ovf  [0:ND];
  logic [51:0] dv_rem  [0:ND][4];
  logic [16:0] dv_q    [0:ND][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= n2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_lin[0]  <= n2_lin;
      dv_den[0]  <= n2_den;
      dv_zero[0] <= n2_den == 31'd0;
      dv_neg[0]  <= n2_neg;
      dv_nz[0]   <= n2_nz;
      for (int i = 0; i < 4; i++) begin
        dv_ovf[0][i] <= n2_n[i] >= (52'(n2_den) << (ND + 1));
        dv_rem[0][i] <= n2_n[i];
        dv_q[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int SH = ND - 1 - k;
    logic [51:0] dk;
    assign dk = 52'(dv_den[k]) << (SH + 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_lin[k+1]  <= dv_lin[k];
        dv_den[k+1]  <= dv_den[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_nz[k+1]   <= dv_nz[k];
        dv_ovf[k+1]  <= dv_ovf[k];
        for (int i = 0; i < 4; i++) begin
          if (dv_rem[k][i] >= dk) begin
            dv_rem[k+1][i] <= dv_rem[k][i] - dk;
            dv_q[k+1][i]   <= dv_q[k][i] | (17'd1 << SH);
          end else begin
            dv_rem[k+1][i] <= dv_rem[k][i];
            dv_q[k+1][i]   <= dv_q[k][i];
          end
        end
      end
    end
  end

  // sign, clamp and saturation flag
  logic signed [15:0] fin_c [4];
  logic [3:0]         fin_sat;
  qslerp_pkg::res_t   fin;
  logic [16:0]        qf;

  always_comb begin
    qf = '0;
    for (int i = 0; i < 4; i++) begin
      qf         = dv_q[ND][i];
      fin_sat[i] = 1'b0;
      if (dv_zero[ND]) begin
        fin_sat[i] = 1'b1;
        if (!dv_nz[ND][i]) begin
          fin_c[i] = '0;
        end else begin
          fin_c[i] = dv_neg[ND][i] ? qslerp_pkg::OUT_MIN : qslerp_pkg::OUT_MAX;
        end
      end else if (dv_ovf[ND][i]) begin
        fin_sat[i] = 1'b1;
        fin_c[i]   = dv_neg[ND][i] ? qslerp_pkg::OUT_MIN : qslerp_pkg::OUT_MAX;
      end else if (dv_neg[ND][i]) begin
        if (qf > 17'd32768) begin
          fin_sat[i] = 1'b1;
          fin_c[i]   = qslerp_pkg::OUT_MIN;
        end else begin
          fin_c[i] = 16'(17'd0 - qf);
        end
      end else begin
        if (qf > 17'd32767) begin
          fin_sat[i] = 1'b1;
          fin_c[i]   = qslerp_pkg::OUT_MAX;
        end else begin
          fin_c[i] = qf[15:0];
        end
      end
    end
    fin.x   = fin_c[0];
    fin.y   = fin_c[1];
    fin.z   = fin_c[2];
    fin.w   = fin_c[3];
    fin.lin = dv_lin[ND];
    fin.sat = |fin_sat;
  end

  // output register plus one skid entry, so a beat that arrives after the consumer
  // stops taking beats is held in the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (skid_v) begin
      if (result_ready) begin
        skid_v <= 1'b0;
      end
    end else if (!result_valid || result_ready) begin
      result_valid <= dv_vld[ND];
    end else if (dv_vld[ND]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (result_ready) begin
        out_r <= skid;
      end
    end else if (!result_valid || result_ready) begin
      out_r <= fin;
    end else begin
      skid <= fin;
    end
  end

  assign out_x       = out_r.x;
  assign out_y       = out_r.y;
  assign out_z       = out_r.z;
  assign out_w       = out_r.w;
  assign used_linear = out_r.lin;
  assign saturated   = out_r.sat;

  // sin(theta) from the root never exceeds one in q30
  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    (ac_vld[0] && !ac_c[0].lin) |-> (ac_s[0] <= 31'h40000000))
    else $error("slerp divisor above one");

  // folded angles must lie in [-pi/2, pi/2] before the sine cordic
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    sn_vld[0] |-> (sn_z[0][0] <= qslerp_pkg::HALF_PI_Q &&
                   sn_z[0][0] >= -qslerp_pkg::HALF_PI_Q &&
                   sn_z[0][1] <= qslerp_pkg::HALF_PI_Q &&
                   sn_z[0][1] >= -qslerp_pkg::HALF_PI_Q))
    else $error("angle reduction out of range");

  // a finished quotient leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_vld[ND] && !dv_zero[ND] && !dv_ovf[ND][0]) |->
      (dv_rem[ND][0] < 52'({dv_den[ND], 1'b0})))
    else $error("divider remainder not reduced");

  // the skid entry is only ever filled behind a waiting result
  a_skid: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid entry without output beat");

  // a held result with no room behind it must stall the input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !result_ready) |=> (skid_v && !item_ready))
    else $error("pipeline advanced while full");

endmodule

`default_nettype wire

/* test/testbench.sv */
// testbench for quaternion_slerp: drives quaternion pairs with a blend factor and checks
// each result against an in-bench slerp / normalized lerp predictor
// depends on qslerp_pkg and quaternion_slerp
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic [15:0]        t;
  } pair_t;

  typedef struct {
    logic signed [15:0] q [4];
    logic               lin;
    logic               sat;
  } quat_res_t;

  localparam longint PI_L      = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint TWO_PI_L  = 64'sd6746518852;
  localparam longint GAIN_L    = 64'sd652032874;
  localparam longint Q30_ONE   = 64'sd1073741824;
  localparam longint DIV_CLAMP = 64'sd1 << 40;
  localparam int     CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic signed [15:0] first_x = '0, first_y = '0, first_z = '0, first_w = '0;
  logic signed [15:0] second_x = '0, second_y = '0, second_z = '0, second_w = '0;
  logic [15:0] blend = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [15:0] out_x, out_y, out_z, out_w;
  logic used_linear, saturated;

  quaternion_slerp dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .item_valid, .item_ready,
    .first_x, .first_y, .first_z, .first_w, .second_x, .second_y, .second_z, .second_w,
    .blend, .result_valid, .result_ready, .out_x, .out_y, .out_z, .out_w,
    .used_linear, .saturated
  );

  always #5 clk = ~clk;

  pair_t     pending_pairs[$];
  quat_res_t expected_quats[$];
  logic [14:0] threshold = qslerp_pkg::THRESHOLD_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;

  function automatic longint asr64(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shift(longint v, int n);
    if (n == 0) return v;
    return (v + (64'sd1 << (n - 1))) >>> n;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arctan_step(int i);
    return longint'(qslerp_pkg::atan_step(i));
  endfunction

  function automatic longint acos_q30(longint d, longint s);
    longint x, y, z, xs, ys;
    if (d < 0) begin
      x = s; y = -d; z = HALF_PI_L;
    end else begin
      x = d; y = s; z = 0;
    end
    for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += arctan_step(i);
      end else begin
        x -= ys; y += xs; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint sin_q30(longint ang);
    longint x, y, z, xs, ys;
    x = GAIN_L;
    y = 0;
    ang = ang % TWO_PI_L;
    if (ang > PI_L) ang -= TWO_PI_L;
    if (ang < -PI_L) ang += TWO_PI_L;
    if (ang > HALF_PI_L) ang = PI_L - ang;
    if (ang < -HALF_PI_L) ang = -PI_L - ang;
    z = ang;
    for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    return y;
  endfunction

  function automatic longint div_nearest(longint num, longint den, ref logic sat);
    longint unsigned un, q;
    if (den <= 0) begin
      sat = 1'b1;
      return num > 0 ? DIV_CLAMP : (num < 0 ? -DIV_CLAMP : 64'sd0);
    end
    un = num < 0 ? longint'(-num) : num;
    q = (2 * un + den) / (2 * longint'(den));
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic quat_res_t interpolate(pair_t p);
    quat_res_t r;
    longint a[4], b[4], res[4], lf[4];
    longint one, t, dot, m, d, s, theta, s0, s1, v;
    longint unsigned sum;
    logic sat;
    one = 64'sd1 << qslerp_pkg::FRAC_BITS;
    t = longint'(p.t);
    dot = 0;
    sat = 1'b0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'(p.a[i]);
      b[i] = longint'(p.b[i]);
      dot += a[i] * b[i];
    end
    if ((dot >>> qslerp_pkg::FRAC_BITS) > longint'(threshold)) begin
      r.lin = 1'b1;
      for (int i = 0; i < 4; i++) begin
        lf[i] = round_shift(a[i] * (one - t) + b[i] * t, qslerp_pkg::FRAC_BITS);
        sum += lf[i] * lf[i];
      end
      m = int_sqrt(sum);
      for (int i = 0; i < 4; i++) res[i] = div_nearest(lf[i] * one, m, sat);
    end else begin
      r.lin = 1'b0;
      d = round_shift(dot, 2 * qslerp_pkg::FRAC_BITS - 30);
      if (d > Q30_ONE) d = Q30_ONE;
      if (d < -Q30_ONE) d = -Q30_ONE;
      s = int_sqrt(Q30_ONE * Q30_ONE - d * d);
      theta = acos_q30(d, s);
      s0 = sin_q30(round_shift(theta * (one - t), qslerp_pkg::FRAC_BITS));
      s1 = sin_q30(round_shift(theta * t, qslerp_pkg::FRAC_BITS));
      for (int i = 0; i < 4; i++) res[i] = div_nearest(a[i] * s0 + b[i] * s1, s, sat);
    end
    for (int i = 0; i < 4; i++) begin
      v = res[i];
      if (v > 32767) begin v = 32767; sat = 1'b1; end
      if (v < -32768) begin v = -32768; sat = 1'b1; end
      r.q[i] = v[15:0];
    end
    r.sat = sat;
    return r;
  endfunction

  // driver: holds the beat until accepted, pops a new one only after a handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pair_t p;
        p = pending_pairs.pop_front();
        expected_quats.push_back(interpolate(p));
        {first_x, first_y, first_z, first_w} <= {p.a[0], p.a[1], p.a[2], p.a[3]};
        {second_x, second_y, second_z, second_w} <= {p.b[0], p.b[1], p.b[2], p.b[3]};
        blend <= p.t;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
    result_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      quat_res_t e;
      if (expected_quats.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if (out_x !== e.q[0]) begin $error("out_x exp %0d got %0d", e.q[0], out_x); errors++; end
        if (out_y !== e.q[1]) begin $error("out_y exp %0d got %0d", e.q[1], out_y); errors++; end
        if (out_z !== e.q[2]) begin $error("out_z exp %0d got %0d", e.q[2], out_z); errors++; end
        if (out_w !== e.q[3]) begin $error("out_w exp %0d got %0d", e.q[3], out_w); errors++; end
        if (used_linear !== e.lin) begin
          $error("used_linear exp %0d got %0d", e.lin, used_linear); errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated exp %0d got %0d", e.sat, saturated); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_slerp: mismatch");
      $finish;
    end
  end

  task automatic add_pair(logic signed [15:0] a0, a1, a2, a3, b0, b1, b2, b3,
                          logic [15:0] t);
    pair_t p;
    p.a = '{a0, a1, a2, a3};
    p.b = '{b0, b1, b2, b3};
    p.t = t;
    pending_pairs.push_back(p);
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($urandom);
  endfunction

  task automatic add_random(int n);
    pair_t p;
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(9);
      for (int i = 0; i < 4; i++) begin
        p.a[i] = rand_comp();
        // near-equal pairs reach the linear path, negated pairs the clamped dot
        if (mode < 3) p.b[i] = p.a[i] + $signed(16'($urandom_range(64))) - 16'sd32;
        else if (mode == 3) p.b[i] = -p.a[i];
        else p.b[i] = rand_comp();
      end
      if (mode == 4) p.a = '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170};
      p.t = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
      pending_pairs.push_back(p);
    end
  endtask

  task automatic write_threshold(logic [14:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    threshold = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_quats.size() > 0 || item_valid)
      @(posedge clk);
    repeat (qslerp_pkg::LATENCY + 20) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, identical, opposite, zero, t past 1.0
    add_pair(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0,
             16'd16384);
    add_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
             -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'd0);
    add_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
             -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'd32768);
    add_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd16384);
    add_pair(16'sd32767, 16'sd0, 16'sd0, 16'sd0, -16'sd32767, 16'sd0, 16'sd0, 16'sd0,
             16'd8192);
    add_pair(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0,
             16'd16384);
    add_pair(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0,
             16'hFFFF);
    add_pair(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
             16'sd16384, 16'sd16384, 16'sd16384, 16'sd16383, 16'd32768);
    add_pair(16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'd20000);
    add_pair(16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 16'sd23170, 16'sd0,
             16'd40000);
    add_pair(-16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'd1);
    send_idle_pct = 11;
    recv_idle_pct = 56;
    add_random(450);
    drain();

    write_threshold(15'd0);
    send_idle_pct = 56;
    recv_idle_pct = 11;
    add_pair(16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'd16384);
    add_random(450);
    drain();

    write_threshold(15'h7FFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(220);
    drain();

    write_threshold(15'd30000);
    add_random(220);
    drain();

    if (errors == 0) begin
      $display("quaternion_slerp: match");
    end else begin
      $display("quaternion_slerp: mismatch");
    end
    $finish;
  end
endmodule
